### design/gbp_pkg.sv
`default_nettype none
package gbp_pkg;

    localparam int GBP_WIDTH     = 128;
    localparam int GBP_PAGES     = 8;
    localparam int GBP_MAX_SCALE = 4;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_PITCH = 6;
    localparam int PAGE_ROWS   = 8;
    localparam int QDEPTH      = 2;

    localparam logic [7:0] CODE_LO    = 8'h20;
    localparam logic [7:0] CODE_HI    = 8'h7E;
    localparam logic [7:0] CODE_QMARK = 8'h3F;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_GLYPH = 2'd1,
        OP_PIXEL = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Classified command handed from the front end to the drawing engine
    typedef struct packed {
        t_op               op;
        logic signed [8:0] pos_x;
        logic signed [8:0] pos_y;
        logic [39:0]       glyph;
        logic [2:0]        scale;
        logic              ink;
        logic [9:0]        read_index;
        logic              in_range;
        logic [4:0]        advance;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic pop;
        logic init;
    } t_bk_stat;

    // Five column bytes per character, first column in the top byte, bit 0 = top row
    localparam logic [39:0] GLYPH_ROM [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    function automatic logic [7:0] glyph_col(input logic [39:0] bits, input logic [2:0] col);
        logic [7:0] c;
        case (col)
            3'd0:    c = bits[39:32];
            3'd1:    c = bits[31:24];
            3'd2:    c = bits[23:16];
            3'd3:    c = bits[15:8];
            3'd4:    c = bits[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### design/glyph_blit_page_framebuffer.sv
// From start accepted to o_done: a byte read steps S_RDB then S_RDD; a pixel write steps
//   S_RD then S_WR, or ends from idle when clipped; a clear walks all WIDTH*PAGES bytes;
//   a glyph walks 5*s screen columns (s the scale), each S_COL then an S_RD/S_WR pair per
//   page it hits, plus any wait queued behind earlier words. One word in the engine at a
//   time; each store byte is a read-modify-write. Reset (i_rst_n low, synchronous) zeroes
//   the whole store, busy high throughout; results strobe once, the receiver cannot stall.
`default_nettype none
module glyph_blit_page_framebuffer
    import gbp_pkg::*;
#(
    parameter int WIDTH     = GBP_WIDTH,
    parameter int PAGES     = GBP_PAGES,
    parameter int MAX_SCALE = GBP_MAX_SCALE
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_opcode,
    input  wire logic signed [8:0] i_pos_x,
    input  wire logic signed [8:0] i_pos_y,
    input  wire logic [7:0]        i_char_code,
    input  wire logic [2:0]        i_glyph_scale,
    input  wire logic              i_ink,
    input  wire logic [9:0]        i_read_index,
    output logic                   o_done,
    output logic [4:0]             o_advance,
    output logic [7:0]             o_read_byte
);

    logic     push;
    t_cmd     cmd;
    t_q_head  head;
    logic     q_full;
    t_bk_stat bk_stat;

    // hold off new words while the queue is full or the store is being zeroed
    assign busy = q_full || bk_stat.init;

    // front end: decode opcode, map character to font bits, clamp scale, check bounds
    gbp_front #(
        .WIDTH     (WIDTH),
        .PAGES     (PAGES),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .i_start       (start),
        .i_busy        (busy),
        .i_opcode      (i_opcode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_char_code   (i_char_code),
        .i_glyph_scale (i_glyph_scale),
        .i_ink         (i_ink),
        .i_read_index  (i_read_index),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    // two-deep queue decouples acceptance from drawing
    gbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (bk_stat.pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    // back end: walks columns and pages, read-modify-write on the frame store
    gbp_back #(
        .WIDTH     (WIDTH),
        .PAGES     (PAGES),
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_stat      (bk_stat),
        .o_done      (o_done),
        .o_advance   (o_advance),
        .o_read_byte (o_read_byte)
    );

endmodule
`default_nettype wire

### design/gbp_ram.sv
`default_nettype none
module gbp_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/gbp_front.sv
`default_nettype none
module gbp_front
    import gbp_pkg::*;
#(
    parameter int WIDTH     = GBP_WIDTH,
    parameter int PAGES     = GBP_PAGES,
    parameter int MAX_SCALE = GBP_MAX_SCALE
) (
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic [1:0]        i_opcode,
    input  wire logic signed [8:0] i_pos_x,
    input  wire logic signed [8:0] i_pos_y,
    input  wire logic [7:0]        i_char_code,
    input  wire logic [2:0]        i_glyph_scale,
    input  wire logic              i_ink,
    input  wire logic [9:0]        i_read_index,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic [7:0] code;
    logic [2:0] scale;
    logic       pix_ok;
    logic       rd_ok;
    t_op        op;

    always_comb begin
        op = t_op'(i_opcode);

        // substitute a question mark for anything outside the printable range
        if (i_char_code < CODE_LO || i_char_code > CODE_HI) begin
            code = CODE_QMARK;
        end else begin
            code = i_char_code;
        end

        if (i_glyph_scale == 3'd0) begin
            scale = 3'd1;
        end else if ({1'b0, i_glyph_scale} > 4'(MAX_SCALE)) begin
            scale = 3'(MAX_SCALE);
        end else begin
            scale = i_glyph_scale;
        end

        pix_ok = (int'(i_pos_x) >= 0) && (int'(i_pos_x) < WIDTH) &&
                 (int'(i_pos_y) >= 0) && (int'(i_pos_y) < PAGES * PAGE_ROWS);
        rd_ok  = int'(i_read_index) < WIDTH * PAGES;

        o_cmd.op         = op;
        o_cmd.pos_x      = i_pos_x;
        o_cmd.pos_y      = i_pos_y;
        o_cmd.glyph      = GLYPH_ROM[7'(code - CODE_LO)];
        o_cmd.scale      = scale;
        o_cmd.ink        = i_ink;
        o_cmd.read_index = i_read_index;
        o_cmd.in_range   = (op == OP_READ) ? rd_ok : pix_ok;
        o_cmd.advance    = 5'(GLYPH_PITCH * int'(scale));

        o_push = i_start && !i_busy;
    end

endmodule
`default_nettype wire

### design/gbp_queue.sv
`default_nettype none
module gbp_queue
    import gbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_q_head   o_head,
    output logic      o_full
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd          r_mem [0:QDEPTH-1];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rp];
    assign o_full       = (r_cnt == CW'(QDEPTH));

endmodule
`default_nettype wire

### design/gbp_back.sv
`default_nettype none
module gbp_back
    import gbp_pkg::*;
#(
    parameter int WIDTH     = GBP_WIDTH,
    parameter int PAGES     = GBP_PAGES,
    parameter int MAX_SCALE = GBP_MAX_SCALE
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_head i_head,
    output t_bk_stat     o_stat,
    output logic         o_done,
    output logic [4:0]   o_advance,
    output logic [7:0]   o_read_byte
);

    localparam int DEPTH = WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int EXPW  = GLYPH_ROWS * MAX_SCALE;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_COL,
        S_RD,
        S_WR,
        S_RDB,
        S_RDD
    } t_state;

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [AW-1:0]       r_cnt, n_cnt;
    logic [AW-1:0]       r_addr, n_addr;
    logic [7:0]          r_win, n_win;
    logic [EXPW-1:0]     r_exp, n_exp;
    logic signed [10:0]  r_ys, n_ys;
    logic signed [10:0]  r_px, n_px;
    logic signed [10:0]  r_pg, n_pg;
    logic signed [10:0]  r_pfirst, n_pfirst;
    logic signed [10:0]  r_plast, n_plast;
    logic [2:0]          r_fc, n_fc;
    logic [2:0]          r_dx, n_dx;
    logic                r_done, n_done;
    logic [4:0]          r_adv, n_adv;
    logic [7:0]          r_rbyte, n_rbyte;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [7:0]          ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;

    logic [7:0]          col_bits;
    logic [7:0]          smask;
    logic [EXPW-1:0]     exp_c;
    logic signed [10:0]  win_sh;
    logic [EXPW+7:0]     win_wide;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_win;
    logic                px_ok;
    logic                col_last;
    logic                col_done;
    logic                pop;
    logic signed [10:0]  h_ys;
    logic signed [10:0]  h_ylast;
    logic signed [10:0]  h_pf;
    logic signed [10:0]  h_pl;

    gbp_ram #(
        .DW    (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        // scaled copy of the current font column, one bit per screen row below the origin
        col_bits = glyph_col(r_cmd.glyph, r_fc);
        smask    = 8'((9'd1 << r_cmd.scale) - 9'd1);
        exp_c    = '0;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            if (col_bits[r]) begin
                exp_c = exp_c | (EXPW'(smask) << (6'(r) * {3'b000, r_cmd.scale}));
            end
        end

        // page bits taken from the scaled column at row offset page*8 - y
        win_sh   = (r_pg <<< 3) - r_ys + 11'sd8;
        win_wide = {r_exp, 8'h00} >> unsigned'(win_sh);

        if (r_cmd.op == OP_GLYPH) begin
            rd_addr = AW'(int'(r_pg) * WIDTH + int'(r_px));
            rd_win  = win_wide[7:0];
        end else begin
            rd_addr = AW'(int'(r_ys >>> 3) * WIDTH + int'(r_px));
            rd_win  = 8'd1 << r_ys[2:0];
        end

        px_ok    = !r_px[10] && (int'(r_px) < WIDTH);
        col_last = (r_fc == 3'(GLYPH_COLS - 1)) && (r_dx == r_cmd.scale - 3'd1);

        // vertical page span of a glyph at the queue head, clipped to the screen
        h_ys    = {{2{i_head.cmd.pos_y[8]}}, i_head.cmd.pos_y};
        h_ylast = h_ys + 11'(GLYPH_ROWS * int'(i_head.cmd.scale)) - 11'sd1;
        h_pf    = h_ys >>> 3;
        h_pl    = h_ylast >>> 3;
        if (h_pf[10]) begin
            h_pf = '0;
        end
        if (h_pl > signed'(11'(PAGES - 1))) begin
            h_pl = signed'(11'(PAGES - 1));
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_cnt    = r_cnt;
        n_addr   = r_addr;
        n_win    = r_win;
        n_exp    = r_exp;
        n_ys     = r_ys;
        n_px     = r_px;
        n_pg     = r_pg;
        n_pfirst = r_pfirst;
        n_plast  = r_plast;
        n_fc     = r_fc;
        n_dx     = r_dx;
        n_done   = 1'b0;
        n_adv    = '0;
        n_rbyte  = '0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = 8'h00;
        ram_raddr = r_addr;
        pop       = 1'b0;
        col_done  = 1'b0;

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                n_cnt     = r_cnt + AW'(1);
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    pop      = 1'b1;
                    n_cmd    = i_head.cmd;
                    n_ys     = h_ys;
                    n_px     = {{2{i_head.cmd.pos_x[8]}}, i_head.cmd.pos_x};
                    n_pfirst = h_pf;
                    n_plast  = h_pl;
                    n_fc     = '0;
                    n_dx     = '0;
                    n_cnt    = '0;
                    case (i_head.cmd.op)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_GLYPH: n_state = S_COL;
                        OP_PIXEL: begin
                            if (i_head.cmd.in_range) begin
                                n_state = S_RD;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        OP_READ:  n_state = S_RDB;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                n_cnt     = r_cnt + AW'(1);
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_COL: begin
                n_exp = exp_c;
                if (px_ok && (r_pfirst <= r_plast)) begin
                    n_pg    = r_pfirst;
                    n_state = S_RD;
                end else begin
                    col_done = 1'b1;
                end
            end
            S_RD: begin
                ram_raddr = rd_addr;
                n_addr    = rd_addr;
                n_win     = rd_win;
                n_state   = S_WR;
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_wdata = r_cmd.ink ? (ram_rdata | r_win) : (ram_rdata & ~r_win);
                if (r_cmd.op == OP_GLYPH) begin
                    if (r_pg < r_plast) begin
                        n_pg    = r_pg + 11'sd1;
                        n_state = S_RD;
                    end else begin
                        col_done = 1'b1;
                    end
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RDB: begin
                ram_raddr = AW'(r_cmd.read_index);
                n_state   = S_RDD;
            end
            S_RDD: begin
                n_done  = 1'b1;
                n_rbyte = r_cmd.in_range ? ram_rdata : 8'h00;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // step to the next screen column of the glyph
        if (col_done) begin
            if (col_last) begin
                n_done  = 1'b1;
                n_adv   = r_cmd.advance;
                n_state = S_IDLE;
            end else begin
                if (r_dx == r_cmd.scale - 3'd1) begin
                    n_dx = '0;
                    n_fc = r_fc + 3'd1;
                end else begin
                    n_dx = r_dx + 3'd1;
                end
                n_px    = r_px + 11'sd1;
                n_state = S_COL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_adv   <= '0;
            r_rbyte <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            r_adv   <= n_adv;
            r_rbyte <= n_rbyte;
        end
        r_cmd    <= n_cmd;
        r_addr   <= n_addr;
        r_win    <= n_win;
        r_exp    <= n_exp;
        r_ys     <= n_ys;
        r_px     <= n_px;
        r_pg     <= n_pg;
        r_pfirst <= n_pfirst;
        r_plast  <= n_plast;
        r_fc     <= n_fc;
        r_dx     <= n_dx;
    end

    assign o_stat.pop  = pop;
    assign o_stat.init = (r_state == S_INIT);
    assign o_done      = r_done;
    assign o_advance   = r_adv;
    assign o_read_byte = r_rbyte;

endmodule
`default_nettype wire

### design/gbp_checker.sv
`default_nettype none
module gbp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic [4:0] o_advance,
    input wire logic [7:0] o_read_byte
);

    // store is zeroed after reset, so no word can be taken right away
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low after reset");

    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (o_advance == 5'd0 && o_read_byte == 8'd0))
        else $error("result fields nonzero without strobe");

    a_glyph_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_advance != 5'd0) |-> (o_read_byte == 8'd0))
        else $error("glyph result carries a read byte");

endmodule

bind glyph_blit_page_framebuffer gbp_checker u_gbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_done      (o_done),
    .o_advance   (o_advance),
    .o_read_byte (o_read_byte)
);
`default_nettype wire
